@@ rtl/nearest_palette_color_search_macros.svh @@
// assertion macros for the nearest palette color search block
// no dependencies; included by the top level
`ifndef NEAREST_PALETTE_COLOR_SEARCH_MACROS_SVH
`define NEAREST_PALETTE_COLOR_SEARCH_MACROS_SVH

// same-cycle implication, disabled during reset
`define NPCS_ASSERT_NOW(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("npcs assertion failed");

// next-cycle implication, disabled during reset
`define NPCS_ASSERT_NEXT(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("npcs assertion failed");

`endif

@@ rtl/npcs_pkg.sv @@
// types and constants of the nearest palette color search block
// used by every module of the block; no dependencies
`default_nettype none

package npcs_pkg;

  localparam int MAX_ENTRIES = 256;
  localparam int ADDR_W      = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CNT_W       = 9;
  localparam int IDX_W       = 8;
  localparam int COLOR_W     = 32;
  localparam int DIST_W      = 18;
  localparam int SQ_W        = 16;

  localparam logic [CNT_W-1:0] PALETTE_ENTRIES_RESET = CNT_W'(256);
  localparam logic [CNT_W-1:0] MAX_COUNT             = CNT_W'(MAX_ENTRIES);

  typedef enum logic {
    CMD_WRITE = 1'b0,
    CMD_QUERY = 1'b1
  } command_t;

  typedef struct packed {
    command_t             command;
    logic [IDX_W-1:0]     entry_index;
    logic [COLOR_W-1:0]   color;
  } item_t;

  typedef struct packed {
    logic [IDX_W-1:0]     nearest_index;
    logic [DIST_W-1:0]    distance;
  } result_t;

  // controller to datapath
  typedef struct packed {
    logic write;
    logic load;
    logic issue;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic last;
    logic drained;
  } dp_status_t;

endpackage

`default_nettype wire

@@ rtl/nearest_palette_color_search.sv @@
// top level of the nearest palette color search block
// depends on npcs_pkg, npcs_ctrl, npcs_datapath and the assertion macro header
//
// usage:
//   an item is transferred when start is high and busy is low. a write item
//   (command write) stores color in palette slot entry_index in that cycle
//   and gives no result; slots at or above the palette size are ignored.
//   a query item (command query) searches entries 0 .. palette_entries-1
//   for the least squared ARGB distance, lowest index on ties.
//   cfg_we with cfg_data sets palette_entries (0 acts as 1, values above
//   the palette size saturate); write it only while busy is low.
//   timing: a write leaves busy low. a query holds busy high after the
//   transfer while the single memory read port gives one entry per cycle
//   for each searched entry, then while the read, square and compare
//   pipeline drains, and then in the done state; done pulses in that
//   last state with the result, and the next item can be taken in the
//   cycle after.
//   the receiver cannot stall: result is valid only while done is high.
//   reset (rst, synchronous) returns to idle and sets palette_entries to
//   256; palette contents are undefined until written.
`default_nettype none
`include "nearest_palette_color_search_macros.svh"

module nearest_palette_color_search (
  input  wire                         clk,
  input  wire                         rst,
  input  wire                         start,
  output logic                        busy,
  input  npcs_pkg::item_t             item,
  output logic                        done,
  output npcs_pkg::result_t           result,
  input  wire                         cfg_we,
  input  wire  [npcs_pkg::CNT_W-1:0]  cfg_data
);

  npcs_pkg::dp_cmd_t    dp_cmd;
  npcs_pkg::dp_status_t dp_status;
  logic                 is_query;

  assign is_query = (item.command == npcs_pkg::CMD_QUERY);

  npcs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .is_query (is_query),
    .status   (dp_status),
    .cmd      (dp_cmd),
    .busy     (busy),
    .done     (done)
  );

  npcs_datapath u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cmd      (dp_cmd),
    .item     (item),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .status   (dp_status),
    .result   (result)
  );

  `NPCS_ASSERT_NEXT(a_query_goes_busy, clk, rst, start && !busy && is_query, busy)
  `NPCS_ASSERT_NEXT(a_done_returns_idle, clk, rst, done, !busy && !done)
  `NPCS_ASSERT_NOW(a_done_after_drain, clk, rst, done, dp_status.drained)
  `NPCS_ASSERT_NOW(a_no_read_when_idle, clk, rst, !busy, !dp_cmd.issue)

endmodule

`default_nettype wire

@@ rtl/npcs_ctrl.sv @@
// controller state machine of the nearest palette color search block
// depends on npcs_pkg
`default_nettype none

module npcs_ctrl (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  start,
  input  wire                  is_query,
  input  npcs_pkg::dp_status_t status,
  output npcs_pkg::dp_cmd_t    cmd,
  output logic                 busy,
  output logic                 done
);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_SCAN  = 4'b0010,
    S_DRAIN = 4'b0100,
    S_DONE  = 4'b1000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    busy       = 1'b1;
    done       = 1'b0;
    case (state)
      S_IDLE: begin
        busy = 1'b0;
        if (start) begin
          if (is_query) begin
            cmd.load   = 1'b1;
            state_next = S_SCAN;
          end else begin
            cmd.write = 1'b1;
          end
        end
      end
      S_SCAN: begin
        cmd.issue = 1'b1;
        if (status.last) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (status.drained) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        done       = 1'b1;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

@@ rtl/npcs_datapath.sv @@
// palette memory, distance pipeline and best-match registers
// depends on npcs_pkg
`default_nettype none

module npcs_datapath (
  input  wire                                 clk,
  input  wire                                 rst,
  input  npcs_pkg::dp_cmd_t                   cmd,
  input  npcs_pkg::item_t                     item,
  input  wire                                 cfg_we,
  input  wire  [npcs_pkg::CNT_W-1:0]          cfg_data,
  output npcs_pkg::dp_status_t                status,
  output npcs_pkg::result_t                   result
);

  logic [npcs_pkg::COLOR_W-1:0] mem [npcs_pkg::MAX_ENTRIES];

  logic [npcs_pkg::CNT_W-1:0]   palette_entries;
  logic [npcs_pkg::CNT_W-1:0]   count_sat;
  logic [npcs_pkg::ADDR_W-1:0]  addr;
  logic [npcs_pkg::ADDR_W-1:0]  last_addr;
  logic [npcs_pkg::COLOR_W-1:0] query;

  logic [npcs_pkg::COLOR_W-1:0] rd_data;
  logic [npcs_pkg::ADDR_W-1:0]  rd_idx;
  logic                         rd_valid;

  logic [npcs_pkg::SQ_W-1:0]    sq [4];
  logic [npcs_pkg::SQ_W-1:0]    sq_next [4];
  logic [npcs_pkg::ADDR_W-1:0]  sq_idx;
  logic                         sq_valid;

  logic [npcs_pkg::DIST_W-1:0]  sum;
  logic [npcs_pkg::DIST_W-1:0]  best_dist;
  logic [npcs_pkg::ADDR_W-1:0]  best_idx;
  logic                         wr_ok;

  // zero searches entry zero alone, large counts saturate
  always_comb begin
    if (palette_entries == '0) begin
      count_sat = npcs_pkg::CNT_W'(1);
    end else if (palette_entries > npcs_pkg::MAX_COUNT) begin
      count_sat = npcs_pkg::MAX_COUNT;
    end else begin
      count_sat = palette_entries;
    end
  end

  assign wr_ok = ({1'b0, item.entry_index} < npcs_pkg::MAX_COUNT);

  always_ff @(posedge clk) begin
    if (rst) begin
      palette_entries <= npcs_pkg::PALETTE_ENTRIES_RESET;
    end else if (cfg_we) begin
      palette_entries <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.write && wr_ok) begin
      mem[item.entry_index[npcs_pkg::ADDR_W-1:0]] <= item.color;
    end
    if (cmd.issue) begin
      rd_data <= mem[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      addr      <= '0;
      last_addr <= npcs_pkg::ADDR_W'(count_sat - npcs_pkg::CNT_W'(1));
      query     <= item.color;
    end else if (cmd.issue) begin
      addr <= addr + npcs_pkg::ADDR_W'(1);
    end
    rd_idx <= addr;
  end

  // per-channel squared difference
  always_comb begin
    logic [7:0] x;
    logic [7:0] y;
    logic [7:0] d;
    for (int k = 0; k < 4; k++) begin
      x = rd_data[8*k +: 8];
      y = query[8*k +: 8];
      d = (x > y) ? (x - y) : (y - x);
      sq_next[k] = npcs_pkg::SQ_W'(d) * npcs_pkg::SQ_W'(d);
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 4; k++) begin
      sq[k] <= sq_next[k];
    end
    sq_idx <= rd_idx;
  end

  assign sum = npcs_pkg::DIST_W'(sq[0]) + npcs_pkg::DIST_W'(sq[1]) +
               npcs_pkg::DIST_W'(sq[2]) + npcs_pkg::DIST_W'(sq[3]);

  // all ones exceeds any real distance, so entry zero always takes it
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      best_dist <= '1;
      best_idx  <= '0;
    end else if (sq_valid && (sum < best_dist)) begin
      best_dist <= sum;
      best_idx  <= sq_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid <= 1'b0;
      sq_valid <= 1'b0;
    end else begin
      rd_valid <= cmd.issue;
      sq_valid <= rd_valid;
    end
  end

  assign status.last          = (addr == last_addr);
  assign status.drained       = !rd_valid && !sq_valid;
  assign result.nearest_index = npcs_pkg::IDX_W'(best_idx);
  assign result.distance      = best_dist;

endmodule

`default_nettype wire

@@ tb/tb_top.sv @@
// testbench for nearest_palette_color_search: directed table, then random palette writes and queries
// results are checked against table values or an in-bench predictor; depends on npcs_pkg and the rtl
`timescale 1ns / 100ps

module tb_top;

  localparam int CYCLE_LIMIT = 2000000;
  localparam int WRITE_SETTLE = 4;

  typedef enum logic {
    ROW_ITEM,
    ROW_CFG
  } row_kind_t;

  typedef struct {
    row_kind_t                      kind;
    npcs_pkg::item_t                it;
    logic [npcs_pkg::CNT_W-1:0]     cfg;
    bit                             typed;
    npcs_pkg::result_t              want;
  } stim_row_t;

  logic                        clk;
  logic                        rst;
  logic                        start;
  logic                        busy;
  npcs_pkg::item_t             item;
  logic                        done;
  npcs_pkg::result_t           result;
  logic                        cfg_we;
  logic [npcs_pkg::CNT_W-1:0]  cfg_data;

  // predictor state
  logic [npcs_pkg::COLOR_W-1:0] palette_copy [npcs_pkg::MAX_ENTRIES];
  logic [npcs_pkg::CNT_W-1:0]   entries_copy;
  npcs_pkg::result_t            pending_results [$];

  stim_row_t directed [$];

  int errors = 0;
  int cycles = 0;

  nearest_palette_color_search DUT (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .busy     (busy),
    .item     (item),
    .done     (done),
    .result   (result),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  function automatic logic [npcs_pkg::DIST_W-1:0] argb_distance(
      logic [npcs_pkg::COLOR_W-1:0] a, logic [npcs_pkg::COLOR_W-1:0] b);
    logic [npcs_pkg::DIST_W-1:0] sum;
    int x;
    int y;
    sum = '0;
    for (int ch = 0; ch < 4; ch++) begin
      x = a[ch*8 +: 8];
      y = b[ch*8 +: 8];
      sum += npcs_pkg::DIST_W'((x - y) * (x - y));
    end
    return sum;
  endfunction

  function automatic int searched_count(logic [npcs_pkg::CNT_W-1:0] v);
    if (v == 0) return 1;
    if (v > npcs_pkg::MAX_ENTRIES) return npcs_pkg::MAX_ENTRIES;
    return int'(v);
  endfunction

  function automatic npcs_pkg::result_t nearest_color(logic [npcs_pkg::COLOR_W-1:0] c);
    npcs_pkg::result_t best;
    logic [npcs_pkg::DIST_W-1:0] d;
    best.nearest_index = '0;
    best.distance = argb_distance(palette_copy[0], c);
    for (int i = 1; i < searched_count(entries_copy); i++) begin
      d = argb_distance(palette_copy[i], c);
      if (d < best.distance) begin
        best.distance = d;
        best.nearest_index = npcs_pkg::IDX_W'(i);
      end
    end
    return best;
  endfunction

  // result checker; the receiver cannot stall, so every done cycle is a transfer
  always @(posedge clk) begin
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result: nearest_index %0d distance %0d",
               result.nearest_index, result.distance);
        errors++;
      end else begin
        npcs_pkg::result_t want;
        want = pending_results.pop_front();
        if (result.nearest_index !== want.nearest_index) begin
          $error("nearest_index expected %0d actual %0d",
                 want.nearest_index, result.nearest_index);
          errors++;
        end
        if (result.distance !== want.distance) begin
          $error("distance expected %0d actual %0d", want.distance, result.distance);
          errors++;
        end
      end
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  // called at a falling edge; returns at a falling edge with start possibly still high
  task automatic send_item(input npcs_pkg::item_t it, input bit typed,
                           input npcs_pkg::result_t want, input int gap);
    start <= 1'b1;
    item <= it;
    forever begin
      @(posedge clk);
      if (!busy) break;
    end
    if (it.command == npcs_pkg::CMD_WRITE) begin
      if (it.entry_index < npcs_pkg::MAX_ENTRIES) palette_copy[it.entry_index] = it.color;
    end else begin
      pending_results.insert(pending_results.size(),
                             typed ? want : nearest_color(it.color));
    end
    @(negedge clk);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap - 1) @(negedge clk);
      @(negedge clk);
    end
  endtask

  // hold off new items until every outstanding query has answered
  task automatic drain();
    start <= 1'b0;
    while (pending_results.size() != 0 || busy) @(negedge clk);
    repeat (WRITE_SETTLE) @(negedge clk);
  endtask

  task automatic program_entries(input logic [npcs_pkg::CNT_W-1:0] v);
    drain();
    cfg_we <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    entries_copy = v;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic stim_row_t row(row_kind_t kind, npcs_pkg::command_t cmd, int idx,
                                    logic [npcs_pkg::COLOR_W-1:0] color, int cfg,
                                    bit typed, int want_idx, int want_dist);
    stim_row_t r;
    r.kind = kind;
    r.it.command = cmd;
    r.it.entry_index = npcs_pkg::IDX_W'(idx);
    r.it.color = color;
    r.cfg = npcs_pkg::CNT_W'(cfg);
    r.typed = typed;
    r.want.nearest_index = npcs_pkg::IDX_W'(want_idx);
    r.want.distance = npcs_pkg::DIST_W'(want_dist);
    return r;
  endfunction

  function automatic void add_row(row_kind_t kind, npcs_pkg::command_t cmd, int idx,
                                  logic [npcs_pkg::COLOR_W-1:0] color, int cfg,
                                  bit typed, int want_idx, int want_dist);
    directed.insert(directed.size(),
                    row(kind, cmd, idx, color, cfg, typed, want_idx, want_dist));
  endfunction

  function automatic logic [npcs_pkg::COLOR_W-1:0] pick_write_color(int current);
    logic [7:0] levels [4];
    logic [npcs_pkg::COLOR_W-1:0] c;
    levels = '{8'h00, 8'hFF, 8'h80, 8'h7F};
    case ($urandom_range(0, 3))
      0, 1: c = $urandom;
      2: begin
        for (int ch = 0; ch < 4; ch++) c[ch*8 +: 8] = levels[$urandom_range(0, 3)];
      end
      default: c = palette_copy[$urandom_range(0, current - 1)];
    endcase
    return c;
  endfunction

  function automatic logic [npcs_pkg::COLOR_W-1:0] pick_query_color(int current);
    logic [npcs_pkg::COLOR_W-1:0] c;
    case ($urandom_range(0, 3))
      0: c = $urandom;
      1: c = palette_copy[$urandom_range(0, current - 1)];
      2: begin
        c = palette_copy[$urandom_range(0, current - 1)];
        for (int ch = 0; ch < 4; ch++)
          c[ch*8 +: 8] = c[ch*8 +: 8] + 8'($urandom_range(0, 6)) - 8'd3;
      end
      default: begin
        for (int ch = 0; ch < 4; ch++) c[ch*8 +: 8] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
      end
    endcase
    return c;
  endfunction

  initial begin
    logic [npcs_pkg::CNT_W-1:0] phase_counts [6];
    logic [npcs_pkg::CNT_W-1:0] cnt;
    npcs_pkg::item_t it;
    npcs_pkg::result_t none;
    int current;
    int gap;
    int phase_len;
    bit no_idle;

    rst = 1'b1;
    start = 1'b0;
    item = '0;
    cfg_we = 1'b0;
    cfg_data = '0;
    none = '0;
    entries_copy = npcs_pkg::PALETTE_ENTRIES_RESET;
    for (int i = 0; i < npcs_pkg::MAX_ENTRIES; i++) palette_copy[i] = '0;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // ties go to entry 0 over its duplicate in entry 3
    add_row(ROW_CFG,  npcs_pkg::CMD_WRITE, 0,   32'h0,        4, 0, 0, 0);
    add_row(ROW_ITEM, npcs_pkg::CMD_WRITE, 0,   32'h00000000, 0, 0, 0, 0);
    add_row(ROW_ITEM, npcs_pkg::CMD_WRITE, 1,   32'hFFFFFFFF, 0, 0, 0, 0);
    add_row(ROW_ITEM, npcs_pkg::CMD_WRITE, 2,   32'h80808080, 0, 0, 0, 0);
    add_row(ROW_ITEM, npcs_pkg::CMD_WRITE, 3,   32'h00000000, 0, 0, 0, 0);
    add_row(ROW_ITEM, npcs_pkg::CMD_QUERY, 0,   32'h00000000, 0, 1, 0, 0);
    add_row(ROW_ITEM, npcs_pkg::CMD_QUERY, 0,   32'hFFFFFFFF, 0, 1, 1, 0);
    add_row(ROW_ITEM, npcs_pkg::CMD_QUERY, 255, 32'h80808080, 0, 1, 2, 0);
    add_row(ROW_ITEM, npcs_pkg::CMD_QUERY, 0,   32'h40404040, 0, 0, 0, 0);
    add_row(ROW_ITEM, npcs_pkg::CMD_QUERY, 255, 32'hFF000000, 0, 0, 0, 0);
    add_row(ROW_ITEM, npcs_pkg::CMD_WRITE, 3,   32'h01020304, 0, 0, 0, 0);
    add_row(ROW_ITEM, npcs_pkg::CMD_QUERY, 0,   32'h01020304, 0, 1, 3, 0);
    add_row(ROW_CFG,  npcs_pkg::CMD_WRITE, 0,   32'h0,        1, 0, 0, 0);
    add_row(ROW_ITEM, npcs_pkg::CMD_QUERY, 0,   32'hFFFFFFFF, 0, 1, 0, 260100);
    // a zero count searches entry 0 alone
    add_row(ROW_CFG,  npcs_pkg::CMD_WRITE, 0,   32'h0,        0, 0, 0, 0);
    add_row(ROW_ITEM, npcs_pkg::CMD_QUERY, 0,   32'hFFFFFFFF, 0, 1, 0, 260100);
    add_row(ROW_ITEM, npcs_pkg::CMD_QUERY, 0,   32'h00000000, 0, 1, 0, 0);
    add_row(ROW_CFG,  npcs_pkg::CMD_WRITE, 0,   32'h0,        2, 0, 0, 0);
    add_row(ROW_ITEM, npcs_pkg::CMD_QUERY, 0,   32'h80808080, 0, 0, 0, 0);
    add_row(ROW_ITEM, npcs_pkg::CMD_QUERY, 0,   32'h7F7F7F7F, 0, 0, 0, 0);

    foreach (directed[i]) begin
      if (directed[i].kind == ROW_CFG) program_entries(directed[i].cfg);
      else send_item(directed[i].it, directed[i].typed, directed[i].want, pick_gap());
    end

    // fill every slot so any count can be searched from here on
    for (int i = 0; i < npcs_pkg::MAX_ENTRIES; i++) begin
      it.command = npcs_pkg::CMD_WRITE;
      it.entry_index = npcs_pkg::IDX_W'(i);
      it.color = pick_write_color(i + 1);
      send_item(it, 0, none, pick_gap());
    end

    // fixed counts first, the oversized one saturating to the full palette, then random counts
    phase_counts = '{9'd511, 9'd1, 9'd256, 9'd0, 9'd2, 9'd255};
    for (int phase = 0; phase < 12; phase++) begin
      if (phase < 6) cnt = phase_counts[phase];
      else if ($urandom_range(0, 2) == 0) cnt = npcs_pkg::CNT_W'($urandom_range(0, 511));
      else cnt = npcs_pkg::CNT_W'($urandom_range(1, 16));
      program_entries(cnt);
      current = searched_count(cnt);
      no_idle = ($urandom_range(0, 3) == 0);
      phase_len = $urandom_range(85, 110);
      for (int n = 0; n < phase_len; n++) begin
        it.command = ($urandom_range(0, 99) < 55) ? npcs_pkg::CMD_QUERY
                                                  : npcs_pkg::CMD_WRITE;
        if (it.command == npcs_pkg::CMD_WRITE && $urandom_range(0, 3) != 0)
          it.entry_index = npcs_pkg::IDX_W'($urandom_range(0, current - 1));
        else
          it.entry_index = npcs_pkg::IDX_W'($urandom_range(0, npcs_pkg::MAX_ENTRIES - 1));
        it.color = (it.command == npcs_pkg::CMD_WRITE)
                   ? pick_write_color(npcs_pkg::MAX_ENTRIES)
                   : pick_query_color(current);
        gap = no_idle ? 0 : pick_gap();
        send_item(it, 0, none, gap);
        if ($urandom_range(0, 49) == 0) drain();
      end
    end

    drain();
    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
